// File: sv/utf8_text_color_markup_parser_unit_assert.svh
// assertion macros for the utf8 text colour markup parser
// used by the top level only, no other dependencies
`ifndef UTF8_TEXT_COLOR_MARKUP_PARSER_UNIT_ASSERT_SVH
`define UTF8_TEXT_COLOR_MARKUP_PARSER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define UTCM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define UTCM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define UTCM_ASSERT(lbl, prop, msg)
`define UTCM_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// File: sv/utf8tcm_pkg.sv
// shared types and constants for the utf8 text colour markup parser
// no dependencies
package utf8tcm_pkg;

  localparam int unsigned TEXT_BYTE_W = 8;
  localparam int unsigned CP_W        = 21;
  localparam int unsigned COLOR_W     = 32;

  localparam logic [COLOR_W-1:0] DEFAULT_COLOR_RST = 32'hFFFF_FFFF;
  localparam logic [COLOR_W-1:0] ALPHA_FULL        = 32'hFF00_0000;

  localparam logic [CP_W-1:0] CP_SPACE = 21'h00_0020;
  localparam logic [CP_W-1:0] CP_CARET = 21'h00_005E;
  localparam logic [CP_W-1:0] CP_R     = 21'h00_0072;
  localparam logic [CP_W-1:0] CP_DIG0  = 21'h00_0030;
  localparam logic [CP_W-1:0] CP_DIG9  = 21'h00_0039;
  localparam logic [CP_W-1:0] CP_HEXA  = 21'h00_0061;
  localparam logic [CP_W-1:0] CP_HEXF  = 21'h00_0066;

  localparam logic [TEXT_BYTE_W-1:0] LEAD2_MASK = 8'b1110_0000;
  localparam logic [TEXT_BYTE_W-1:0] LEAD2_VAL  = 8'b1100_0000;
  localparam logic [TEXT_BYTE_W-1:0] LEAD3_MASK = 8'b1111_0000;
  localparam logic [TEXT_BYTE_W-1:0] LEAD3_VAL  = 8'b1110_0000;
  localparam logic [TEXT_BYTE_W-1:0] LEAD4_MASK = 8'b1111_1000;
  localparam logic [TEXT_BYTE_W-1:0] LEAD4_VAL  = 8'b1111_0000;

  localparam logic KIND_GLYPH = 1'b0;
  localparam logic KIND_SPACE = 1'b1;

  typedef enum logic [4:0] {
    MODE_NORMAL = 5'b00001,
    MODE_CARET  = 5'b00010,
    MODE_DIG1   = 5'b00100,
    MODE_DIG2   = 5'b01000,
    MODE_DIG3   = 5'b10000
  } mode_t;

  typedef struct packed {
    logic               stopped;
    mode_t              mode;
    logic [1:0]         pending;
    logic [CP_W-1:0]    acc;
    logic [COLOR_W-1:0] color;
  } prs_state_t;

  typedef struct packed {
    logic               valid;
    logic               kind;
    logic [CP_W-1:0]    cp;
    logic [COLOR_W-1:0] color;
  } prs_result_t;

endpackage

// File: sv/utf8_text_color_markup_parser_unit.sv
// top level of the utf8 text colour markup parser: input register, step logic,
// result register; depends on utf8tcm_pkg, utf8tcm_step and the assertion header
// path: a byte is held in the input register, and its result in the result register
// throughput: one byte per cycle, the per-byte state update is a single step
// no stall unless the result register is full and out_tready is low
// reset (rst_n low, synchronous): registers empty, default colour 0xFFFFFFFF
`include "utf8_text_color_markup_parser_unit_assert.svh"
module utf8_text_color_markup_parser_unit
  import utf8tcm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [COLOR_W-1:0]  cfg_data,   // default_color
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // text_byte
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [55:0]         out_tdata,  // code_point [20:0], draw_color_out [52:21], zero
  output logic                out_tuser   // event_kind
);

  logic [COLOR_W-1:0]     default_color_r;
  logic                   in_valid_r;
  logic [TEXT_BYTE_W-1:0] in_byte_r;
  prs_state_t             state_r;
  prs_state_t             state_nxt;
  prs_result_t            res;
  logic                   out_valid_r;
  logic                   out_kind_r;
  logic [CP_W-1:0]        out_cp_r;
  logic [COLOR_W-1:0]     out_color_r;
  logic                   proc_fire;

  assign cfg_ready = 1'b1;
  assign proc_fire = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || proc_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_color_r <= DEFAULT_COLOR_RST;
    end else if (cfg_valid) begin
      default_color_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  utf8tcm_step u_step (
    .text_byte     (in_byte_r),
    .default_color (default_color_r),
    .cur           (state_r),
    .nxt           (state_nxt),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{stopped: 1'b0, mode: MODE_NORMAL, pending: 2'd0, acc: '0,
                   color: DEFAULT_COLOR_RST};
    end else if (proc_fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_fire) begin
      out_valid_r <= res.valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && res.valid) begin
      out_kind_r  <= res.kind;
      out_cp_r    <= res.cp;
      out_color_r <= res.color;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {3'b000, out_color_r, out_cp_r};

  `UTCM_ASSERT_RST(a_rst_empty, !rst_n |=> !out_tvalid, "result register not empty after reset")
  `UTCM_ASSERT(a_stopped_silent,
    (proc_fire && state_r.stopped && in_byte_r != '0) |=> !out_valid_r,
    "result while stopped")
  `UTCM_ASSERT(a_space_cp,
    (proc_fire && res.valid && res.kind == KIND_SPACE) |=> (out_cp_r == CP_SPACE),
    "space item with wrong code point")
  `UTCM_ASSERT(a_zero_restart,
    (proc_fire && in_byte_r == '0) |=> (state_r.color == $past(default_color_r) &&
      !state_r.stopped && state_r.mode == MODE_NORMAL),
    "zero byte did not restart text")

endmodule

// File: sv/utf8tcm_step.sv
// one text byte step: utf8 decode, markup mode and colour update, result
// depends on utf8tcm_pkg
module utf8tcm_step
  import utf8tcm_pkg::*;
(
  input  logic [TEXT_BYTE_W-1:0] text_byte,
  input  logic [COLOR_W-1:0]     default_color,
  input  prs_state_t             cur,
  output prs_state_t             nxt,
  output prs_result_t            res
);

  logic            have_cp;
  logic            end_now;
  logic            is_dig;
  logic            is_hex;
  logic            build;
  logic [3:0]      hex_val;
  logic [CP_W-1:0] cp;
  logic [CP_W-1:0] acc_n;
  logic [1:0]      pend_n;
  prs_state_t      dec_st;

  assign is_dig = (cur.mode == MODE_DIG1) || (cur.mode == MODE_DIG2) ||
                  (cur.mode == MODE_DIG3);
  assign acc_n  = {cur.acc[CP_W-7:0], text_byte[5:0]};
  assign pend_n = cur.pending - 2'd1;

  always_comb begin
    have_cp = 1'b0;
    end_now = 1'b0;
    cp      = '0;
    dec_st  = cur;
    if (text_byte != '0 && !cur.stopped) begin
      if (cur.pending == 2'd0) begin
        if (!text_byte[7]) begin
          cp      = {{(CP_W-TEXT_BYTE_W){1'b0}}, text_byte};
          have_cp = 1'b1;
        end else if ((text_byte & LEAD2_MASK) == LEAD2_VAL) begin
          dec_st.acc     = {{(CP_W-5){1'b0}}, text_byte[4:0]};
          dec_st.pending = 2'd1;
        end else if ((text_byte & LEAD3_MASK) == LEAD3_VAL) begin
          dec_st.acc     = {{(CP_W-4){1'b0}}, text_byte[3:0]};
          dec_st.pending = 2'd2;
        end else if ((text_byte & LEAD4_MASK) == LEAD4_VAL) begin
          dec_st.acc     = {{(CP_W-3){1'b0}}, text_byte[2:0]};
          dec_st.pending = 2'd3;
        end else begin
          end_now = 1'b1;
        end
      end else begin
        dec_st.pending = pend_n;
        if (pend_n == 2'd0) begin
          cp         = acc_n;
          have_cp    = 1'b1;
          dec_st.acc = '0;
        end else begin
          dec_st.acc = acc_n;
        end
      end
      if (have_cp && cp == '0) begin
        have_cp = 1'b0;
        end_now = 1'b1;
      end
    end
  end

  // hex digit detection on the decoded code point
  always_comb begin
    is_hex  = 1'b0;
    hex_val = '0;
    if (cp >= CP_DIG0 && cp <= CP_DIG9) begin
      is_hex  = 1'b1;
      hex_val = cp[3:0];
    end else if (cp >= CP_HEXA && cp <= CP_HEXF) begin
      is_hex  = 1'b1;
      hex_val = cp[3:0] + 4'd9;
    end
  end

  prs_state_t  st_cp;
  prs_result_t res_cp;

  always_comb begin
    st_cp  = dec_st;
    res_cp = '0;
    build  = 1'b0;
    case (cur.mode)
      MODE_CARET: begin
        if (cp == CP_R) begin
          st_cp.color = default_color;
          st_cp.mode  = MODE_NORMAL;
        end else begin
          build = 1'b1;
        end
      end
      MODE_DIG1, MODE_DIG2: begin
        build = 1'b1;
      end
      MODE_DIG3: begin
        st_cp.color = cur.color | ALPHA_FULL;
        st_cp.mode  = MODE_NORMAL;
        res_cp      = '{valid: 1'b1, kind: KIND_GLYPH, cp: cp, color: st_cp.color};
      end
      default: begin
        st_cp.mode = MODE_NORMAL;
        if (cp == CP_SPACE) begin
          res_cp = '{valid: 1'b1, kind: KIND_SPACE, cp: CP_SPACE, color: cur.color};
        end else if (cp == CP_CARET) begin
          st_cp.color = '0;
          st_cp.mode  = MODE_CARET;
        end else begin
          res_cp = '{valid: 1'b1, kind: KIND_GLYPH, cp: cp, color: cur.color};
        end
      end
    endcase
    if (build) begin
      if (is_hex) begin
        st_cp.color = (cur.color >> 8) | {8'h00, hex_val, hex_val, 16'h0000};
        case (cur.mode)
          MODE_CARET: st_cp.mode = MODE_DIG1;
          MODE_DIG1:  st_cp.mode = MODE_DIG2;
          default:    st_cp.mode = MODE_DIG3;
        endcase
      end else begin
        st_cp.color = (cur.color >> 8) | ALPHA_FULL;
        st_cp.mode  = MODE_NORMAL;
        res_cp      = '{valid: 1'b1, kind: KIND_GLYPH, cp: cp, color: st_cp.color};
      end
    end
  end

  prs_state_t final_st;

  always_comb begin
    final_st = dec_st;
    res      = '0;
    if (text_byte == '0) begin
      if (!cur.stopped && is_dig) begin
        res = '{valid: 1'b1, kind: KIND_GLYPH, cp: '0, color: cur.color | ALPHA_FULL};
      end
      final_st = '{stopped: 1'b0, mode: MODE_NORMAL, pending: 2'd0, acc: '0,
                   color: default_color};
    end else if (end_now) begin
      if (is_dig) begin
        res = '{valid: 1'b1, kind: KIND_GLYPH, cp: '0, color: cur.color | ALPHA_FULL};
        final_st.color = cur.color | ALPHA_FULL;
      end
      final_st.mode    = MODE_NORMAL;
      final_st.pending = 2'd0;
      final_st.acc     = '0;
      final_st.stopped = 1'b1;
    end else if (have_cp) begin
      final_st = st_cp;
      res      = res_cp;
    end
  end

  assign nxt = final_st;

endmodule

// File: verif/glyph_event_checker.sv
`timescale 1ns / 100ps
// checker for the utf8 text colour markup parser: watches the config, text and event
// channels, predicts each glyph or space event and compares; depends on utf8tcm_pkg
module glyph_event_checker
  import utf8tcm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [COLOR_W-1:0] cfg_data,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [7:0]         in_tdata,
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [55:0]        out_tdata,
  input  logic               out_tuser,
  output int                 n_fail,
  output int                 n_waiting
);

  logic [COLOR_W-1:0] dflt_color;
  logic [COLOR_W-1:0] cur_color;
  logic [1:0]         cont_left;
  logic [CP_W-1:0]    cp_acc;
  mode_t              mk_mode;
  logic               text_stopped;
  prs_result_t        glyph_events_due[$];

  function automatic int hex_nibble(input logic [CP_W-1:0] cp);
    if (cp >= CP_DIG0 && cp <= CP_DIG9) return int'(cp - CP_DIG0);
    if (cp >= CP_HEXA && cp <= CP_HEXF) return int'(cp - CP_HEXA) + 10;
    return -1;
  endfunction

  function automatic prs_result_t glyph_event(input logic kind, input logic [CP_W-1:0] cp,
                                              input logic [COLOR_W-1:0] col);
    prs_result_t ev;
    ev.valid = 1'b1;
    ev.kind  = kind;
    ev.cp    = cp;
    ev.color = col;
    return ev;
  endfunction

  task automatic restart_text();
    cont_left    = 2'd0;
    cp_acc       = '0;
    mk_mode      = MODE_NORMAL;
    cur_color    = dflt_color;
    text_stopped = 1'b0;
  endtask

  // a colour built from digits still yields a glyph of code point zero
  task automatic close_text(output prs_result_t ev);
    ev = '0;
    if (mk_mode == MODE_DIG1 || mk_mode == MODE_DIG2 || mk_mode == MODE_DIG3) begin
      cur_color = cur_color | ALPHA_FULL;
      ev = glyph_event(KIND_GLYPH, '0, cur_color);
    end
    mk_mode   = MODE_NORMAL;
    cont_left = 2'd0;
    cp_acc    = '0;
  endtask

  task automatic apply_code_point(input logic [CP_W-1:0] cp, output prs_result_t ev);
    int nib;
    ev  = '0;
    nib = hex_nibble(cp);
    case (mk_mode)
      MODE_CARET, MODE_DIG1, MODE_DIG2: begin
        if (mk_mode == MODE_CARET && cp == CP_R) begin
          cur_color = dflt_color;
          mk_mode   = MODE_NORMAL;
        end else begin
          cur_color = cur_color >> 8;
          if (nib >= 0) begin
            cur_color = cur_color | ((32'(nib) * 32'h11) << 16);
            if (mk_mode == MODE_CARET) mk_mode = MODE_DIG1;
            else if (mk_mode == MODE_DIG1) mk_mode = MODE_DIG2;
            else mk_mode = MODE_DIG3;
          end else begin
            cur_color = cur_color | ALPHA_FULL;
            mk_mode   = MODE_NORMAL;
            ev = glyph_event(KIND_GLYPH, cp, cur_color);
          end
        end
      end
      MODE_DIG3: begin
        cur_color = cur_color | ALPHA_FULL;
        mk_mode   = MODE_NORMAL;
        ev = glyph_event(KIND_GLYPH, cp, cur_color);
      end
      default: begin
        mk_mode = MODE_NORMAL;
        if (cp == CP_SPACE) begin
          ev = glyph_event(KIND_SPACE, CP_SPACE, cur_color);
        end else if (cp == CP_CARET) begin
          cur_color = '0;
          mk_mode   = MODE_CARET;
        end else begin
          ev = glyph_event(KIND_GLYPH, cp, cur_color);
        end
      end
    endcase
  endtask

  task automatic decode_text_byte(input logic [7:0] b, output prs_result_t ev);
    logic [CP_W-1:0] cp;
    logic            have_cp;
    ev      = '0;
    cp      = '0;
    have_cp = 1'b0;
    if (b == 8'h00) begin
      if (!text_stopped) close_text(ev);
      restart_text();
    end else if (!text_stopped) begin
      if (cont_left == 2'd0) begin
        if (!b[7]) begin
          cp      = {13'b0, b};
          have_cp = 1'b1;
        end else if ((b & LEAD2_MASK) == LEAD2_VAL) begin
          cp_acc    = {13'b0, b & 8'h1F};
          cont_left = 2'd1;
        end else if ((b & LEAD3_MASK) == LEAD3_VAL) begin
          cp_acc    = {13'b0, b & 8'h0F};
          cont_left = 2'd2;
        end else if ((b & LEAD4_MASK) == LEAD4_VAL) begin
          cp_acc    = {13'b0, b & 8'h07};
          cont_left = 2'd3;
        end else begin
          close_text(ev);
          text_stopped = 1'b1;
        end
      end else begin
        cp_acc    = {cp_acc[CP_W-7:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0) begin
          cp      = cp_acc;
          cp_acc  = '0;
          have_cp = 1'b1;
        end
      end
      if (have_cp) begin
        if (cp == '0) begin
          close_text(ev);
          text_stopped = 1'b1;
        end else begin
          apply_code_point(cp, ev);
        end
      end
    end
  endtask

  always @(posedge clk) begin : watch
    prs_result_t ev;
    prs_result_t want;
    if (!rst_n) begin
      dflt_color = DEFAULT_COLOR_RST;
      restart_text();
      glyph_events_due.delete();
      n_fail    = 0;
      n_waiting = 0;
    end else begin
      if (cfg_valid && cfg_ready) dflt_color = cfg_data;
      if (out_tvalid && out_tready) begin
        if (glyph_events_due.size() == 0) begin
          n_fail++;
          if (n_fail <= 100)
            $display("%0t: unexpected event, expected none, actual kind %0d cp %h colour %h",
                     $time, out_tuser, out_tdata[20:0], out_tdata[52:21]);
        end else begin
          want = glyph_events_due.pop_front();
          if (want.kind !== out_tuser || want.cp !== out_tdata[20:0] ||
              want.color !== out_tdata[52:21]) begin
            n_fail++;
            if (n_fail <= 100)
              $display("%0t: event mismatch, expected kind %0d cp %h colour %h, %s %0d cp %h colour %h",
                       $time, want.kind, want.cp, want.color, "actual kind",
                       out_tuser, out_tdata[20:0], out_tdata[52:21]);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        decode_text_byte(in_tdata, ev);
        if (ev.valid) glyph_events_due = {glyph_events_due, ev};
      end
      n_waiting = glyph_events_due.size();
    end
  end

endmodule

// File: verif/utf8_text_color_markup_parser_unit_tb.sv
`timescale 1ns / 100ps
// testbench top for the utf8 text colour markup parser: drives text bytes, colour writes
// and sink back-pressure; depends on utf8tcm_pkg, the dut and glyph_event_checker
module utf8_text_color_markup_parser_unit_tb;
  import utf8tcm_pkg::*;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = CP_SPACE[7:0];
  localparam logic [7:0] CH_CARET = CP_CARET[7:0];
  localparam logic [7:0] CH_R     = CP_R[7:0];

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [COLOR_W-1:0] cfg_data;
  logic               in_tvalid;
  logic               in_tready;
  logic [7:0]         in_tdata;
  logic               out_tvalid;
  logic               out_tready;
  logic [55:0]        out_tdata;
  logic               out_tuser;
  int                 n_fail;
  int                 n_waiting;
  int                 n_sent = 0;
  logic               quiet = 1'b0;
  logic               hold_req = 1'b0;
  logic               hold_done = 1'b0;

  always #5 clk = ~clk;

  utf8_text_color_markup_parser_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  glyph_event_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .n_fail     (n_fail),
    .n_waiting  (n_waiting)
  );

  // sink: random idling, one long hold-off on request
  initial begin : sink
    int hold_left;
    hold_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= quiet || ($urandom_range(0, 99) >= 25);
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    logic took;
    while (!quiet && $urandom_range(0, 99) < 25) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = in_tready;
      @(posedge clk);
    end
    n_sent++;
  endtask

  task automatic write_default_color(input logic [COLOR_W-1:0] c);
    logic took;
    in_tvalid <= 1'b0;
    do @(negedge clk); while (n_waiting != 0);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= c;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] hex_char(input int d);
    if (d < 10) return CP_DIG0[7:0] + 8'(d);
    return CP_HEXA[7:0] + 8'(d - 10);
  endfunction

  // continuation bytes are not checked, so some carry arbitrary top bits
  function automatic logic [7:0] cont_byte();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(1, 255));
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  task automatic push_multibyte();
    int nb;
    nb = $urandom_range(2, 4);
    case (nb)
      2: push_byte(LEAD2_VAL | 8'($urandom_range(0, 31)));
      3: push_byte(LEAD3_VAL | 8'($urandom_range(0, 15)));
      default: push_byte(LEAD4_VAL | 8'($urandom_range(0, 7)));
    endcase
    repeat (nb - 1) push_byte(cont_byte());
  endtask

  task automatic push_markup();
    int ndig;
    push_byte(CH_CARET);
    if ($urandom_range(0, 5) == 0) begin
      push_byte(CH_R);
    end else begin
      ndig = $urandom_range(0, 3);
      repeat (ndig) push_byte(hex_char($urandom_range(0, 15)));
      case ($urandom_range(0, 4))
        0: push_byte(CH_SPACE);
        1: push_byte(CH_CARET);
        2: push_multibyte();
        default: push_byte(8'($urandom_range(1, 127)));
      endcase
    end
  endtask

  task automatic push_text(input int n_parts);
    int k;
    for (int i = 0; i < n_parts; i++) begin
      k = $urandom_range(0, 99);
      if (k < 35) push_byte(8'($urandom_range(8'h21, 8'h7E)));
      else if (k < 50) push_byte(CH_SPACE);
      else if (k < 75) push_markup();
      else if (k < 93) push_multibyte();
      else push_byte(8'($urandom_range(1, 255)));
    end
    if ($urandom_range(0, 9) < 8) push_byte(CH_NUL);
  endtask

  task automatic push_noise();
    repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(0, 255)));
    push_byte(CH_NUL);
  endtask

  function automatic logic [COLOR_W-1:0] pick_color(input int phase);
    case (phase)
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h00FF_00FF;
      default: return 32'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    int phase;
    int next_cfg;
    rst_n     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // space, full colour, restore, one digit, caret then non-hex
    push_byte(CH_SPACE);
    push_byte(CH_CARET); push_byte(8'h61); push_byte(8'h62); push_byte(8'h63); push_byte(8'h58);
    push_byte(CH_CARET); push_byte(CH_R);
    push_byte(CH_CARET); push_byte(8'h35); push_byte(8'h5A);
    push_byte(CH_CARET); push_byte(8'h51);
    // largest four byte sequence
    push_byte(8'hF4); push_byte(8'h8F); push_byte(8'hBF); push_byte(8'hBF);
    // text ends after two digits, then right after a caret on a bad lead byte
    push_byte(CH_CARET); push_byte(8'h31); push_byte(8'h32); push_byte(CH_NUL);
    push_byte(CH_CARET); push_byte(8'h80); push_byte(8'hFF); push_byte(CH_NUL);
    // sequence decoding to zero, bad lead of five bytes
    push_byte(8'hC0); push_byte(8'h80); push_byte(CH_NUL);
    push_byte(8'hF8); push_byte(CH_NUL); push_byte(8'h7F);

    phase    = 0;
    next_cfg = n_sent;
    while (n_sent < 1930) begin
      if (n_sent >= next_cfg) begin
        write_default_color(pick_color(phase));
        phase++;
        next_cfg = n_sent + 250;
        quiet = (phase == 2);
        if (phase == 4) hold_req = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) push_noise();
      else push_text($urandom_range(1, 12));
    end

    in_tvalid <= 1'b0;
    do @(negedge clk); while (n_waiting != 0);
    repeat (10) @(posedge clk);
    if (n_fail == 0 && n_waiting == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
